FILE: rtl/cubic_deinterlace_filter_defines.svh
// ----------------------------------------------------------------------------
// cubic deinterlace filter assertion macros
// shared check forms for the deinterlace filter rtl
// ----------------------------------------------------------------------------
`ifndef CUBIC_DEINTERLACE_FILTER_DEFINES_SVH
`define CUBIC_DEINTERLACE_FILTER_DEFINES_SVH

// consequent holds in the same cycle
`define CDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define CDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg
// widths, register indexes and fixed constants of the deinterlace filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdf_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_W    = 2;
  localparam int SLOTS     = 3;
  localparam int ACC_W     = 14;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] LINE_BYTES_RESET = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_ROWS_RESET = 13'd480;
  localparam logic [CFG_W-1:0] MAX_ROWS         = 13'd4096;

  localparam logic [ROW_W-1:0] FIRST_OUT_ROW = 12'd6;
  localparam logic [ROW_W-1:0] ROW_OFFSET    = 12'd3;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [PIX_W-1:0]     pix;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    slot_t                slot;
  } tap_ctrl_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_inc = (s == slot_t'(SLOTS - 1)) ? '0 : s + slot_t'(1);
  endfunction

endpackage

FILE: rtl/cubic_deinterlace_filter.sv
// ----------------------------------------------------------------------------
// cubic_deinterlace_filter
// result path: tap stage registers (byte and line store reads), then the result register
// throughput: one byte per cycle while pixel_stall is low, set by the single read of each line store ram
// reset: counters to row 0 column 0, registers to 640 bytes and 480 rows
// line stores are not cleared; no start-up pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cubic_deinterlace_filter_defines.svh"

module cubic_deinterlace_filter #(
  parameter int MAX_LINE_BYTES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [cdf_pkg::CFG_IDX_W-1:0]     reg_index,
  input  logic [cdf_pkg::CFG_W-1:0]         write_data,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [cdf_pkg::PIX_W-1:0]         pixel_in,
  input  logic                              frame_start,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [cdf_pkg::PIX_W-1:0]         value,
  output logic [cdf_pkg::ROW_W-1:0]         out_row,
  output logic [cdf_pkg::OUT_COL_W-1:0]     out_column,
  output logic                              last_of_frame
);

  localparam int CW   = $clog2(MAX_LINE_BYTES);
  localparam int LW   = $clog2(MAX_LINE_BYTES + 1);
  localparam int LENW = (LW > cdf_pkg::CFG_W) ? LW : cdf_pkg::CFG_W;

  logic [cdf_pkg::CFG_W-1:0] line_bytes;
  logic [cdf_pkg::CFG_W-1:0] frame_rows;

  logic [CW-1:0]                column_count, column_count_next;
  logic [cdf_pkg::ROW_W-1:0]    row_count, row_count_next;
  cdf_pkg::slot_t               row_slot, row_slot_next;

  logic                         accept;
  logic [CW-1:0]                col_cur;
  logic [cdf_pkg::ROW_W-1:0]    row_cur;
  cdf_pkg::slot_t               slot_cur;
  logic [LENW-1:0]              len_eff;
  logic [cdf_pkg::CFG_W-1:0]    rows_eff;
  logic                         col_end, row_end, row_live;
  logic                         store_we;
  cdf_pkg::tap_ctrl_t           s0_ctrl;

  logic                         s1_valid;
  cdf_pkg::tap_ctrl_t           s1_ctrl;
  logic                         s1_advance;

  logic [cdf_pkg::PIX_W-1:0]    ram_rdata [cdf_pkg::SLOTS];
  logic [cdf_pkg::PIX_W-1:0]    tap_a, tap_b, tap_c;
  logic [cdf_pkg::PIX_W:0]      mid_sum;
  logic [cdf_pkg::ACC_W-2:0]    mid_prod;
  logic signed [cdf_pkg::ACC_W-1:0] acc;
  logic [cdf_pkg::PIX_W-1:0]    value_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes <= cdf_pkg::LINE_BYTES_RESET;
      frame_rows <= cdf_pkg::FRAME_ROWS_RESET;
    end else if (write_enable) begin
      case (reg_index)
        cdf_pkg::REG_LINE_BYTES: line_bytes <= write_data;
        cdf_pkg::REG_FRAME_ROWS: frame_rows <= write_data;
        default: ;
      endcase
    end
  end

  // position of the incoming byte
  assign accept   = pixel_valid && !pixel_stall;
  assign col_cur  = frame_start ? '0 : column_count;
  assign row_cur  = frame_start ? '0 : row_count;
  assign slot_cur = frame_start ? '0 : row_slot;

  always_comb begin
    if (line_bytes == '0) begin
      len_eff = LENW'(1);
    end else if (LENW'(line_bytes) > LENW'(MAX_LINE_BYTES)) begin
      len_eff = LENW'(MAX_LINE_BYTES);
    end else begin
      len_eff = LENW'(line_bytes);
    end
    if (frame_rows == '0) begin
      rows_eff = cdf_pkg::CFG_W'(1);
    end else if (frame_rows > cdf_pkg::MAX_ROWS) begin
      rows_eff = cdf_pkg::MAX_ROWS;
    end else begin
      rows_eff = frame_rows;
    end
  end

  assign col_end  = (LENW'(col_cur) + LENW'(1)) >= len_eff;
  assign row_end  = ({1'b0, row_cur} + cdf_pkg::CFG_W'(1)) >= rows_eff;
  assign row_live = !row_cur[0] && ({1'b0, row_cur} < rows_eff);
  assign store_we = accept && row_live;

  always_comb begin
    s0_ctrl.emit = row_live && (row_cur >= cdf_pkg::FIRST_OUT_ROW);
    s0_ctrl.last = col_end && (({1'b0, row_cur} + cdf_pkg::CFG_W'(2)) >= rows_eff);
    s0_ctrl.pix  = pixel_in;
    s0_ctrl.row  = row_cur - cdf_pkg::ROW_OFFSET;
    s0_ctrl.col  = cdf_pkg::OUT_COL_W'(col_cur);
    s0_ctrl.slot = slot_cur;
  end

  always_comb begin
    if (col_end) begin
      column_count_next = '0;
      if (row_end) begin
        row_count_next = '0;
        row_slot_next  = '0;
      end else begin
        row_count_next = row_cur + cdf_pkg::ROW_W'(1);
        row_slot_next  = row_cur[0] ? cdf_pkg::slot_inc(slot_cur) : slot_cur;
      end
    end else begin
      column_count_next = col_cur + CW'(1);
      row_count_next    = row_cur;
      row_slot_next     = slot_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_slot     <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      row_slot     <= row_slot_next;
    end
  end

  // line stores, one per even row slot
  for (genvar k = 0; k < cdf_pkg::SLOTS; k++) begin : g_line
    cdf_ram #(
      .WIDTH (cdf_pkg::PIX_W),
      .DEPTH (MAX_LINE_BYTES)
    ) u_ram (
      .clk   (clk),
      .we    (store_we && (slot_cur == cdf_pkg::slot_t'(k))),
      .waddr (col_cur),
      .wdata (pixel_in),
      .re    (accept),
      .raddr (col_cur),
      .rdata (ram_rdata[k])
    );
  end

  // tap stage
  assign s1_advance  = s1_valid && (!s1_ctrl.emit || !result_valid || !result_stall);
  assign pixel_stall = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl <= s0_ctrl;
    end
  end

  always_comb begin
    case (s1_ctrl.slot)
      cdf_pkg::slot_t'(0): begin
        tap_a = ram_rdata[0];
        tap_b = ram_rdata[1];
        tap_c = ram_rdata[2];
      end
      cdf_pkg::slot_t'(1): begin
        tap_a = ram_rdata[1];
        tap_b = ram_rdata[2];
        tap_c = ram_rdata[0];
      end
      default: begin
        tap_a = ram_rdata[2];
        tap_b = ram_rdata[0];
        tap_c = ram_rdata[1];
      end
    endcase
  end

  // nine times the inner pair, less the outer pair, divided by sixteen, then clamp
  assign mid_sum  = {1'b0, tap_b} + {1'b0, tap_c};
  assign mid_prod = {(cdf_pkg::ACC_W-4)'(mid_sum), 3'b000}
                  + (cdf_pkg::ACC_W-1)'(mid_sum);
  assign acc = $signed({1'b0, mid_prod})
             - $signed({(cdf_pkg::ACC_W-cdf_pkg::PIX_W)'(0), tap_a})
             - $signed({(cdf_pkg::ACC_W-cdf_pkg::PIX_W)'(0), s1_ctrl.pix});

  always_comb begin
    if (acc[cdf_pkg::ACC_W-1]) begin
      value_next = '0;
    end else if (acc[cdf_pkg::ACC_W-2:cdf_pkg::PIX_W+4] != '0) begin
      value_next = '1;
    end else begin
      value_next = acc[cdf_pkg::PIX_W+3:4];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && s1_ctrl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_ctrl.emit) begin
      value         <= value_next;
      out_row       <= s1_ctrl.row;
      out_column    <= s1_ctrl.col;
      last_of_frame <= s1_ctrl.last;
    end
  end

  `CDF_ASSERT_SAME(a_stall_needs_item, pixel_stall, s1_valid && s1_ctrl.emit, "stall without a pending result")
  `CDF_ASSERT_SAME(a_out_row_odd, result_valid, out_row[0], "result for an even row")
  `CDF_ASSERT_NEXT(a_result_loaded, s1_advance && s1_ctrl.emit, result_valid, "tap result not loaded")
  `CDF_ASSERT_SAME(a_slot_range, 1'b1, row_slot != cdf_pkg::slot_t'(cdf_pkg::SLOTS), "line slot out of range")

endmodule

FILE: rtl/cdf_ram.sv
// ----------------------------------------------------------------------------
// cdf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// bench for the cubic deinterlace filter: frames of bytes go in through the
// pixel channel and every interpolated odd-row byte that comes back is
// compared field by field with a line-store model kept inside the bench.
// directed frames cover reset values, clamping, short frames, frame start
// in mid-frame, shrinking the registers mid-frame and the register extremes,
// and random frames run under three idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_LINE      = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 70;

  typedef struct packed {
    logic [cdf_pkg::PIX_W-1:0]     value;
    logic [cdf_pkg::ROW_W-1:0]     row;
    logic [cdf_pkg::OUT_COL_W-1:0] col;
    logic                          last;
  } odd_byte_t;

  logic                          clk;
  logic                          rst;
  logic                          write_enable;
  logic [cdf_pkg::CFG_IDX_W-1:0] reg_index;
  logic [cdf_pkg::CFG_W-1:0]     write_data;
  logic                          pixel_valid;
  logic                          pixel_stall;
  logic [cdf_pkg::PIX_W-1:0]     pixel_in;
  logic                          frame_start;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [cdf_pkg::PIX_W-1:0]     value;
  logic [cdf_pkg::ROW_W-1:0]     out_row;
  logic [cdf_pkg::OUT_COL_W-1:0] out_column;
  logic                          last_of_frame;

  // bench copy of the line stores, position and registers
  logic [cdf_pkg::PIX_W-1:0] line_mem [0:3*MAX_LINE-1];
  int unsigned               row_pos;
  int unsigned               col_pos;
  logic [cdf_pkg::CFG_W-1:0] cfg_line;
  logic [cdf_pkg::CFG_W-1:0] cfg_rows;

  odd_byte_t odd_row_bytes[$];
  int        mismatch_count = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        idle_cycles;

  cubic_deinterlace_filter #(
    .MAX_LINE_BYTES(MAX_LINE)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_in     (pixel_in),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .out_row      (out_row),
    .out_column   (out_column),
    .last_of_frame(last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void advance_deinterlace(input logic [cdf_pkg::PIX_W-1:0] pix,
                                              input logic fs);
    int unsigned len, rows, r, c, h;
    int          s, va, vb, vc;
    odd_byte_t   e;
    len  = (cfg_line == 0) ? 1 : (cfg_line > MAX_LINE) ? MAX_LINE : cfg_line;
    rows = (cfg_rows == 0) ? 1 :
           (cfg_rows > cdf_pkg::MAX_ROWS) ? cdf_pkg::MAX_ROWS : cfg_rows;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos % MAX_LINE;
    h = r >> 1;
    if ((r % 2) == 0 && r < rows) begin
      if (r >= 6) begin
        va = line_mem[(h % 3) * MAX_LINE + c];
        vb = line_mem[((h + 1) % 3) * MAX_LINE + c];
        vc = line_mem[((h + 2) % 3) * MAX_LINE + c];
        s  = 9 * (vb + vc) - va - int'(pix);
        if (s < 0) e.value = '0;
        else if ((s >> 4) > 255) e.value = 8'hff;
        else e.value = cdf_pkg::PIX_W'(s >> 4);
        e.row  = cdf_pkg::ROW_W'(r - 3);
        e.col  = cdf_pkg::OUT_COL_W'(c);
        e.last = (c + 1 >= len) && (r + 2 >= rows);
        odd_row_bytes.push_back(e);
      end
      line_mem[(h % 3) * MAX_LINE + c] = pix;
    end
    if (c + 1 >= len) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void count_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  function automatic logic [cdf_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(19))
      0, 1, 2: rand_pixel = 8'h00;
      3, 4, 5: rand_pixel = 8'hff;
      default: rand_pixel = cdf_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic send_pixel(input logic [cdf_pkg::PIX_W-1:0] pix, input logic fs);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_in    <= pix;
    frame_start <= fs;
    do begin
      @(negedge clk);
      taken = !pixel_stall;
      @(posedge clk);
    end while (!taken);
    advance_deinterlace(pix, fs);
  endtask

  task automatic send_run(input int n, input logic first_fs);
    for (int i = 0; i < n; i++) begin
      send_pixel(rand_pixel(), (i == 0) ? first_fs : 1'b0);
    end
  endtask

  // wait for every expected byte, then let the pipeline empty
  task automatic settle_block();
    pixel_valid <= 1'b0;
    while (odd_row_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cdf_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= cdf_pkg::CFG_W'(data);
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
    if (idx == cdf_pkg::REG_LINE_BYTES) cfg_line = cdf_pkg::CFG_W'(data);
    else cfg_rows = cdf_pkg::CFG_W'(data);
  endtask

  task automatic set_geometry(input int unsigned line_cfg, input int unsigned rows_cfg);
    settle_block();
    write_reg(cdf_pkg::REG_LINE_BYTES, line_cfg);
    write_reg(cdf_pkg::REG_FRAME_ROWS, rows_cfg);
  endtask

  task automatic test_reset_values();
    // counters start at row 0 without a frame start
    send_run(40, 1'b0);
  endtask

  task automatic test_clamp_and_wrap();
    logic [cdf_pkg::PIX_W-1:0] pix;
    set_geometry(2, 7);
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 2; c++) begin
        if (r % 2) pix = 8'h5a;
        else pix = (((r == 0) || (r == 6)) ^ (c == 1)) ? 8'h00 : 8'hff;
        send_pixel(pix, (r == 0) && (c == 0));
      end
    end
    // next frame follows on from the counter wrap
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 2; c++) begin
        send_pixel(cdf_pkg::PIX_W'(r * 37 + c * 11 + 100), 1'b0);
      end
    end
  endtask

  task automatic test_short_frames();
    for (int rows = 0; rows < 7; rows++) begin
      set_geometry(3, rows);
      send_run(2 * 3 * ((rows == 0) ? 1 : rows), 1'b1);
    end
  endtask

  task automatic test_frame_start_noise();
    set_geometry(4, 10);
    for (int i = 0; i < 120; i++) begin
      send_pixel(rand_pixel(), (i == 0) || (i == 27) || (i == 61));
    end
  endtask

  task automatic test_midframe_shrink();
    set_geometry(6, 12);
    send_run(8 * 6 + 5, 1'b1);
    // shorter line and frame taking effect part way through a line
    set_geometry(3, 9);
    send_run(2 * 3 * 9, 1'b0);
    set_geometry(6, 12);
    send_run(10 * 6 + 3, 1'b1);
    settle_block();
    write_reg(cdf_pkg::REG_FRAME_ROWS, 8);
    send_run(2 * 6 * 8, 1'b0);
  endtask

  task automatic test_line_extremes();
    set_geometry(MAX_LINE, 1);
    send_run(16, 1'b1);
    set_geometry(8191, 1);
    send_run(16, 1'b1);
    set_geometry(0, 9);
    send_run(18, 1'b1);
  endtask

  task automatic test_row_extremes();
    set_geometry(1, 4096);
    send_run(40, 1'b1);
    set_geometry(1, 8191);
    send_run(40, 1'b1);
  endtask

  task automatic test_random_frames(input int n_items);
    int          sent;
    int          frames;
    int          total;
    int unsigned line_cfg;
    int unsigned rows_cfg;
    int unsigned len;
    int unsigned rows;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       line_cfg = 0;
        1:       line_cfg = $urandom_range(24, 9);
        default: line_cfg = $urandom_range(8, 1);
      endcase
      case ($urandom_range(9))
        0, 1:    rows_cfg = $urandom_range(6, 0);
        2:       rows_cfg = $urandom_range(30, 17);
        default: rows_cfg = $urandom_range(16, 7);
      endcase
      set_geometry(line_cfg, rows_cfg);
      len    = (line_cfg == 0) ? 1 : line_cfg;
      rows   = (rows_cfg == 0) ? 1 : rows_cfg;
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames && sent < n_items; f++) begin
        total = len * rows;
        // truncated frame now and then
        if ($urandom_range(9) == 0) total = $urandom_range(total, 1);
        for (int i = 0; i < total && sent < n_items; i++) begin
          send_pixel(rand_pixel(),
                     ((i == 0) && ((f == 0) || ($urandom_range(1) == 1))) ||
                     ($urandom_range(99) == 0));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // a result transfers at the next rising edge when valid and not stalled
  always @(negedge clk) begin : result_check
    odd_byte_t want;
    if (!rst && result_valid && !result_stall) begin
      if (odd_row_bytes.size() == 0) begin
        count_mismatch($sformatf("unexpected result: value %0d row %0d col %0d last %0b",
                                 value, out_row, out_column, last_of_frame));
      end else begin
        want = odd_row_bytes.pop_front();
        if (value !== want.value || out_row !== want.row ||
            out_column !== want.col || last_of_frame !== want.last) begin
          count_mismatch($sformatf(
            "expected value %0d row %0d col %0d last %0b, got value %0d row %0d col %0d last %0b",
            want.value, want.row, want.col, want.last,
            value, out_row, out_column, last_of_frame));
        end
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || write_enable || (pixel_valid && !pixel_stall) ||
          (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    write_enable = 1'b0;
    reg_index    = cdf_pkg::REG_LINE_BYTES;
    write_data   = '0;
    pixel_valid  = 1'b0;
    pixel_in     = '0;
    frame_start  = 1'b0;
    row_pos      = 0;
    col_pos      = 0;
    cfg_line     = cdf_pkg::LINE_BYTES_RESET;
    cfg_rows     = cdf_pkg::FRAME_ROWS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(29, 48);
    test_reset_values();
    test_clamp_and_wrap();
    test_short_frames();
    test_frame_start_noise();
    test_midframe_shrink();
    test_random_frames(RANDOM_ITEMS);

    set_idling(48, 29);
    test_random_frames(RANDOM_ITEMS);

    set_idling(0, 0);
    test_line_extremes();
    test_row_extremes();
    test_random_frames(RANDOM_ITEMS);

    settle_block();
    if (mismatch_count == 0 && odd_row_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
